/* rtl/bucket_pool_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Bucket pool allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUCKET_POOL_ALLOCATOR_ASSERT_SVH
`define BUCKET_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, constants and tables of the bucket pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int BUCKETS_PER_STEP = 64;
  localparam int MAX_STEPS        = 16;
  localparam int MAX_CORES        = 8;
  localparam int POOL_SIZE        = BUCKETS_PER_STEP * MAX_STEPS;

  localparam int IX_W    = 10;
  localparam int CNT_W   = 11;
  localparam int WORD_W  = 64;
  localparam int WORDS   = POOL_SIZE / WORD_W;
  localparam int WA_W    = 4;
  localparam int BIT_W   = 6;
  localparam int STEP_W  = 5;
  localparam int SLOT_W  = 3;
  localparam int CORE_W  = 8;
  localparam int ECNT_W  = 4;
  localparam int MODE_W  = 3;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 4;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_SLOT    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_GROW   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NF     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PC_RND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PC_NF  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT = 1'd1;

  typedef struct packed {
    logic              func;
    logic [IX_W-1:0]   release_index;
    logic [CORE_W-1:0] core_number;
    logic [IX_W-1:0]   random_start;
  } in_word_t;

  typedef struct packed {
    logic [IX_W-1:0] bucket_index;
    logic [ST_W-1:0] status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_MOD, S_PINIT, S_RD, S_EV, S_COMMIT,
    S_RRD, S_REV, S_RWR, S_DONE
  } state_t;

  typedef struct packed {
    logic            in_ready;
    logic            clr;
    logic            load;
    logic            prep;
    logic            mod;
    logic            pinit;
    logic            eval;
    logic            nextw;
    logic            passb;
    logic            grow;
    logic            commit;
    logic            rel_wr;
    logic            set_st;
    logic [ST_W-1:0] st_code;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_rel;
    logic no_slot;
    logic mod_done;
    logic hit;
    logic last_word;
    logic pass_b_ok;
    logic can_grow;
    logic rel_set;
    logic out_busy;
  } sts_t;

  function automatic logic [CNT_W-1:0] per_size(input logic [ECNT_W-1:0] ec);
    logic [CNT_W-1:0] p;
    unique case (ec)
      4'd2:    p = CNT_W'(POOL_SIZE / 2);
      4'd3:    p = CNT_W'(POOL_SIZE / 3);
      4'd4:    p = CNT_W'(POOL_SIZE / 4);
      4'd5:    p = CNT_W'(POOL_SIZE / 5);
      4'd6:    p = CNT_W'(POOL_SIZE / 6);
      4'd7:    p = CNT_W'(POOL_SIZE / 7);
      4'd8:    p = CNT_W'(POOL_SIZE / 8);
      default: p = CNT_W'(POOL_SIZE);
    endcase
    return p;
  endfunction

endpackage

/* rtl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clear, release, modulo reduction and bitmap word scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_PREP;
      S_PREP: begin
        priority if (sts.is_rel) state_nxt = S_RRD;
        else if (sts.no_slot)    state_nxt = S_DONE;
        else                     state_nxt = S_MOD;
      end
      S_MOD:    if (sts.mod_done) state_nxt = S_PINIT;
      S_PINIT:  state_nxt = S_RD;
      S_RD:     state_nxt = S_EV;
      S_EV: begin
        priority if (sts.hit)   state_nxt = S_COMMIT;
        else if (!sts.last_word) state_nxt = S_RD;
        else if (sts.pass_b_ok)  state_nxt = S_RD;
        else if (sts.can_grow)   state_nxt = S_MOD;
        else                     state_nxt = S_DONE;
      end
      S_COMMIT: state_nxt = S_DONE;
      S_RRD:    state_nxt = S_REV;
      S_REV:    state_nxt = sts.rel_set ? S_RWR : S_DONE;
      S_RWR:    state_nxt = S_DONE;
      S_DONE:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      S_PREP: begin
        priority if (sts.is_rel) begin
        end else if (sts.no_slot) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NO_SLOT;
        end else begin
          cmd.prep = 1'b1;
        end
      end
      S_MOD:    cmd.mod = !sts.mod_done;
      S_PINIT:  cmd.pinit = 1'b1;
      S_RD: begin
      end
      S_EV: begin
        cmd.eval = 1'b1;
        priority if (sts.hit) begin
        end else if (!sts.last_word) begin
          cmd.nextw = 1'b1;
        end else if (sts.pass_b_ok) begin
          cmd.passb = 1'b1;
        end else if (sts.can_grow) begin
          cmd.grow = 1'b1;
        end else begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_EXHAUSTED;
        end
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_RRD: begin
      end
      S_REV: begin
        cmd.eval = 1'b1;
        if (!sts.rel_set) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_DOUBLE_FREE;
        end
      end
      S_RWR:    cmd.rel_wr = 1'b1;
      S_DONE:   cmd.out_load = !sts.out_busy;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/bpa_datapath.sv */
// ----------------------------------------------------------------------------
// bpa_datapath
// Allocator state, bitmap RAM, modulo unit, word mask and bit search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bucket_pool_allocator_assert.svh"

module bpa_datapath import bpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_word_t             in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [MODE_W-1:0] mode_r;
  logic [ECNT_W-1:0] ccount_r;
  logic [CNT_W-1:0]  used_r;
  logic [STEP_W-1:0] act_r;
  logic [IX_W-1:0]   gni_r;
  logic [IX_W-1:0]   cnext_r [MAX_CORES];
  logic              slot_v_r [MAX_CORES];
  logic [CORE_W-1:0] slot_n_r [MAX_CORES];
  in_word_t          in_r;
  logic [SLOT_W-1:0] slot_r;
  logic              noslot_r;
  logic [MODE_W-1:0] emode_r;
  logic [CNT_W-1:0]  len_r;
  logic [IX_W-1:0]   base_r;
  logic [CNT_W-1:0]  modv_r;
  logic [CNT_W-1:0]  lo_r;
  logic [CNT_W-1:0]  hi_r;
  logic [WA_W-1:0]   w_r;
  logic              passb_r;
  logic [WORD_W-1:0] word_r;
  logic [IX_W-1:0]   found_r;
  logic [IX_W-1:0]   res_ix_r;
  logic [ST_W-1:0]   res_st_r;
  out_word_t         out_r;
  logic              out_valid_r;
  logic [WA_W-1:0]   clr_r;

  logic [ECNT_W-1:0] ec;
  logic [CNT_W-1:0]  per;
  logic [MODE_W-1:0] emode;
  logic              pc_mode;
  logic              s_hit;
  logic [SLOT_W-1:0] s_idx;
  logic [CNT_W-1:0]  region;

  logic [WORD_W-1:0] rdata;
  logic              ram_we;
  logic [WA_W-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WA_W-1:0]   ram_raddr;

  logic [STEP_W-1:0] lo_w, hi_w, last_w, w5;
  logic [CNT_W-1:0]  hm1;
  logic [WORD_W-1:0] lomask, himask, cand;
  logic [BIT_W-1:0]  pos;
  logic              hit;

  assign ec = (ccount_r == '0) ? ECNT_W'(1) :
              (ccount_r > ECNT_W'(MAX_CORES)) ? ECNT_W'(MAX_CORES) : ccount_r;
  assign per = per_size(ec);
  assign emode = (mode_r > MODE_PC_NF) ? MODE_GROW : mode_r;
  assign pc_mode = (emode == MODE_PC_RND) || (emode == MODE_PC_NF);
  assign region = CNT_W'({act_r, {BIT_W{1'b0}}});

  always_comb begin
    s_hit = 1'b0;
    s_idx = '0;
    for (int i = MAX_CORES - 1; i >= 0; i--) begin
      if ((ECNT_W'(i) < ec) && (!slot_v_r[i] || slot_n_r[i] == in_data.core_number)) begin
        s_hit = 1'b1;
        s_idx = SLOT_W'(i);
      end
    end
  end

  assign w5     = {1'b0, w_r};
  assign lo_w   = lo_r[CNT_W-1:BIT_W];
  assign hi_w   = hi_r[CNT_W-1:BIT_W];
  assign hm1    = hi_r - CNT_W'(1);
  assign last_w = hm1[CNT_W-1:BIT_W];
  assign lomask = (lo_w < w5) ? '1 :
                  (lo_w == w5) ? ({WORD_W{1'b1}} << lo_r[BIT_W-1:0]) : '0;
  assign himask = (w5 < hi_w) ? '1 :
                  (w5 == hi_w) ? ((WORD_W'(1) << hi_r[BIT_W-1:0]) - WORD_W'(1)) : '0;
  assign cand   = ~rdata & lomask & himask;
  assign hit    = |cand;

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) pos = BIT_W'(i);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    priority if (cmd.clr) begin
      ram_we = 1'b1;
    end else if (cmd.commit) begin
      ram_we    = 1'b1;
      ram_waddr = found_r[IX_W-1:BIT_W];
      ram_wdata = word_r | (WORD_W'(1) << found_r[BIT_W-1:0]);
    end else if (cmd.rel_wr) begin
      ram_we    = 1'b1;
      ram_waddr = in_r.release_index[IX_W-1:BIT_W];
      ram_wdata = word_r & ~(WORD_W'(1) << in_r.release_index[BIT_W-1:0]);
    end
  end

  assign ram_raddr = in_r.func ? in_r.release_index[IX_W-1:BIT_W] : w_r;

  bpa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GROW;
      ccount_r    <= ECNT_W'(1);
      used_r      <= '0;
      act_r       <= STEP_W'(1);
      gni_r       <= '0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      for (int i = 0; i < MAX_CORES; i++) begin
        cnext_r[i]  <= '0;
        slot_v_r[i] <= 1'b0;
        slot_n_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALLOC_MODE: mode_r   <= cfg_wdata[MODE_W-1:0];
          CFG_CORE_COUNT: ccount_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.clr) clr_r <= clr_r + WA_W'(1);
      if (cmd.load) begin
        if (!in_data.func && pc_mode && s_hit && !slot_v_r[s_idx]) begin
          slot_v_r[s_idx] <= 1'b1;
          slot_n_r[s_idx] <= in_data.core_number;
        end
        if (!in_data.func && emode == MODE_GROW && used_r == region &&
            act_r < STEP_W'(MAX_STEPS)) begin
          act_r <= act_r + STEP_W'(1);
        end
      end
      if (cmd.grow) act_r <= act_r + STEP_W'(1);
      if (cmd.pinit && emode_r == MODE_PC_NF) cnext_r[slot_r] <= modv_r[IX_W-1:0];
      if (cmd.commit) begin
        used_r <= used_r + CNT_W'(1);
        if (emode_r == MODE_GROW || emode_r == MODE_NF) gni_r <= found_r;
        if (emode_r == MODE_PC_NF) cnext_r[slot_r] <= found_r - base_r;
      end
      if (cmd.rel_wr) used_r <= used_r - CNT_W'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r     <= in_data;
      slot_r   <= s_idx;
      noslot_r <= !in_data.func && pc_mode && !s_hit;
      emode_r  <= emode;
      res_ix_r <= '0;
      res_st_r <= ST_OK;
    end
    if (cmd.prep) begin
      unique case (emode_r)
        MODE_RAND: begin
          len_r  <= CNT_W'(POOL_SIZE);
          base_r <= '0;
          modv_r <= CNT_W'(in_r.random_start);
        end
        MODE_NF: begin
          len_r  <= CNT_W'(POOL_SIZE);
          base_r <= '0;
          modv_r <= CNT_W'(gni_r);
        end
        MODE_PC_RND: begin
          len_r  <= per;
          base_r <= IX_W'(per * CNT_W'(slot_r));
          modv_r <= CNT_W'(in_r.random_start);
        end
        MODE_PC_NF: begin
          len_r  <= per;
          base_r <= IX_W'(per * CNT_W'(slot_r));
          modv_r <= CNT_W'(cnext_r[slot_r]);
        end
        default: begin
          len_r  <= region;
          base_r <= '0;
          modv_r <= CNT_W'(gni_r);
        end
      endcase
    end
    if (cmd.mod) modv_r <= modv_r - len_r;
    if (cmd.grow) begin
      len_r  <= CNT_W'({act_r + STEP_W'(1), {BIT_W{1'b0}}});
      modv_r <= CNT_W'(gni_r);
    end
    if (cmd.pinit) begin
      lo_r    <= CNT_W'(base_r) + modv_r;
      hi_r    <= CNT_W'(base_r) + len_r;
      w_r     <= WA_W'(CNT_W'(CNT_W'(base_r) + modv_r) >> BIT_W);
      passb_r <= 1'b0;
    end
    if (cmd.nextw) w_r <= w_r + WA_W'(1);
    if (cmd.passb) begin
      lo_r    <= CNT_W'(base_r);
      hi_r    <= CNT_W'(base_r) + modv_r;
      w_r     <= base_r[IX_W-1:BIT_W];
      passb_r <= 1'b1;
    end
    if (cmd.eval) begin
      word_r  <= rdata;
      found_r <= {w_r, pos};
    end
    if (cmd.commit) begin
      res_ix_r <= found_r;
      res_st_r <= ST_OK;
    end
    if (cmd.rel_wr) res_st_r <= ST_OK;
    if (cmd.set_st) res_st_r <= cmd.st_code;
    if (cmd.out_load) begin
      out_r.bucket_index <= res_ix_r;
      out_r.status       <= res_st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.clr_done  = (clr_r == WA_W'(WORDS - 1));
    sts.is_rel    = in_r.func;
    sts.no_slot   = noslot_r;
    sts.mod_done  = (modv_r < len_r);
    sts.hit       = hit;
    sts.last_word = (last_w == w5);
    sts.pass_b_ok = !passb_r && (modv_r != '0);
    sts.can_grow  = (emode_r == MODE_GROW) && (act_r < STEP_W'(MAX_STEPS));
    sts.rel_set   = rdata[in_r.release_index[BIT_W-1:0]];
    sts.out_busy  = out_valid_r && !out_ready;
  end

  `BPA_ASSERT_IMPL(a_used_range, 1'b1, used_r <= CNT_W'(POOL_SIZE))
  `BPA_ASSERT_IMPL(a_act_range, 1'b1, act_r >= STEP_W'(1) && act_r <= STEP_W'(MAX_STEPS))
  `BPA_ASSERT_IMPL(a_commit_free, cmd.commit, !word_r[found_r[BIT_W-1:0]])

endmodule

/* rtl/bucket_pool_allocator.sv */
// Release: the bitmap word is read, checked and rewritten unless already free.
// Allocate: modulo subtraction of the start point, then a scan of each 64-bit
// bitmap word on the single RAM read port, wrapping once; a miss in growing mode
// grows the region if it can, else exhausted; no free core slot gives no-slot.
// One item at a time; the next is taken the cycle after a result is loaded.
// Reset: synchronous; a clear pass zeroes the bitmap RAM before any item.
// ----------------------------------------------------------------------------
// bucket_pool_allocator
// Bitmap bucket allocator with growing, random, next-fit and per-core modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bucket_pool_allocator import bpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data
);

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign in_ready = cmd.in_ready;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Bucket pool allocator testbench
// Drives allocate and release words through every search mode and several core counts,
// predicts each result with a behavioral copy of the pool and checks in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bpa_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;

  bucket_pool_allocator i_dut (.*);

  localparam int WATCHDOG = 20000;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // pool shadow
  bit         pool_used [POOL_SIZE];
  int         n_used;
  int         grow_steps;
  int         next_ix;
  int         core_next [MAX_CORES];
  bit         slot_valid [MAX_CORES];
  logic [7:0] slot_core [MAX_CORES];
  logic [2:0] mode_reg;
  logic [3:0] cores_reg;

  in_word_t  word_q [$];
  out_word_t result_q [$];
  int        errors;
  int        n_accepted;
  int        n_checked;
  int        idle_cycles;

  function automatic bit scan_free(int base, int len, int off, output int found);
    int k;
    for (int i = 0; i < len; i++) begin
      k = off + i;
      if (k >= len) k -= len;
      if (base + k < POOL_SIZE && !pool_used[base + k]) begin
        found = base + k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int cores_eff();
    int c;
    c = cores_reg;
    if (c == 0) c = 1;
    if (c > MAX_CORES) c = MAX_CORES;
    return c;
  endfunction

  function automatic int claim_slot(logic [7:0] cn);
    for (int i = 0; i < cores_eff(); i++) begin
      if (slot_valid[i]) begin
        if (slot_core[i] == cn) return i;
      end else begin
        slot_valid[i] = 1'b1;
        slot_core[i]  = cn;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic out_word_t allocate_or_release(in_word_t w);
    out_word_t r;
    int ix, s, per, start, off, region;
    bit ok;
    ix = 0;
    r.status = ST_OK;
    if (w.func) begin
      if (!pool_used[w.release_index]) r.status = ST_DOUBLE_FREE;
      else begin
        pool_used[w.release_index] = 1'b0;
        n_used--;
      end
    end else begin
      case (mode_reg)
        MODE_RAND: begin
          ok = scan_free(0, POOL_SIZE, w.random_start % POOL_SIZE, ix);
          if (!ok) r.status = ST_EXHAUSTED;
        end
        MODE_NF: begin
          next_ix %= POOL_SIZE;
          ok = scan_free(0, POOL_SIZE, next_ix, ix);
          if (ok) next_ix = ix;
          else r.status = ST_EXHAUSTED;
        end
        MODE_PC_RND, MODE_PC_NF: begin
          s = claim_slot(w.core_number);
          if (s < 0) r.status = ST_NO_SLOT;
          else begin
            per = POOL_SIZE / cores_eff();
            start = per * s;
            if (mode_reg == MODE_PC_NF) begin
              core_next[s] %= per;
              off = core_next[s];
            end else off = w.random_start % per;
            ok = scan_free(start, per, off, ix);
            if (!ok) r.status = ST_EXHAUSTED;
            else if (mode_reg == MODE_PC_NF) core_next[s] = ix - start;
          end
        end
        default: begin
          region = BUCKETS_PER_STEP * grow_steps;
          if (n_used == region && grow_steps < MAX_STEPS) grow_steps++;
          forever begin
            region = BUCKETS_PER_STEP * grow_steps;
            ok = scan_free(0, region, next_ix % region, ix);
            if (ok) begin
              next_ix = ix;
              break;
            end
            if (grow_steps >= MAX_STEPS) begin
              r.status = ST_EXHAUSTED;
              break;
            end
            grow_steps++;
          end
        end
      endcase
      if (r.status == ST_OK) begin
        pool_used[ix] = 1'b1;
        n_used++;
      end else ix = 0;
    end
    r.bucket_index = IX_W'(ix);
    return r;
  endfunction

  // driver
  int in_gap;
  bit in_acc;
  always @(posedge clk) in_acc <= in_valid && in_ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= $urandom_range(0, 17);
    end else if (in_valid && !in_acc) begin
    end else if (in_gap > 0 || word_q.size() == 0) begin
      in_valid <= 1'b0;
      if (in_gap > 0) in_gap <= in_gap - 1;
    end else begin
      in_valid <= 1'b1;
      in_data  <= word_q.pop_front();
      in_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    end
  end

  // receiver stall
  int out_gap;
  int out_draw;
  bit out_acc;
  always @(posedge clk) out_acc <= out_valid && out_ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else if (out_acc) begin
      out_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (out_draw == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        out_gap   <= out_draw - 1;
      end
    end else out_ready <= 1'b1;
  end

  // monitor
  out_word_t exp_w;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) begin
        result_q.push_back(allocate_or_release(in_data));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        n_checked <= n_checked + 1;
        if (result_q.size() == 0) begin
          $error("result with none expected: index %0d status %0d",
                 out_data.bucket_index, out_data.status);
          errors++;
        end else begin
          exp_w = result_q.pop_front();
          if (out_data.bucket_index !== exp_w.bucket_index) begin
            $error("bucket_index expected %0d actual %0d",
                   exp_w.bucket_index, out_data.bucket_index);
            errors++;
          end
          if (out_data.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results outstanding", result_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_word_t mk(bit f, int rel, int cn, int rs);
    in_word_t w;
    w.func = f;
    w.release_index = IX_W'(rel);
    w.core_number = CORE_W'(cn);
    w.random_start = IX_W'(rs);
    return w;
  endfunction

  task automatic drain();
    while (word_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (4 * POOL_SIZE / WORD_W + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_ALLOC_MODE) mode_reg = 3'(val);
    else cores_reg = 4'(val);
  endtask

  // random word: mostly allocations with releases mostly of live buckets
  function automatic in_word_t rand_word(int cores_hint);
    int pick;
    int live [$];
    if ($urandom_range(0, 99) < 45) begin
      for (int i = 0; i < POOL_SIZE; i++) if (pool_used[i]) live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 9) != 0)
        pick = live[$urandom_range(0, live.size() - 1)];
      else pick = $urandom_range(0, POOL_SIZE - 1);
      return mk(1'b1, pick, $urandom_range(0, 255), $urandom_range(0, 1023));
    end
    return mk(1'b0, $urandom_range(0, 1023),
              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, cores_hint + 1),
              $urandom_range(0, 1023));
  endfunction

  initial begin
    int modes [6] = '{0, 1, 2, 3, 4, 6};
    int cores [6] = '{1, 8, 3, 0, 15, 5};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    idle_cycles = 0;
    foreach (pool_used[i]) pool_used[i] = 1'b0;
    n_used = 0;
    grow_steps = 1;
    next_ix = 0;
    foreach (core_next[i]) begin
      core_next[i] = 0;
      slot_valid[i] = 1'b0;
      slot_core[i] = '0;
    end
    mode_reg = MODE_GROW;
    cores_reg = 4'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: growing region, double free, release of the top index, extremes
    for (int i = 0; i < 66; i++) word_q.push_back(mk(1'b0, 0, 0, 0));
    drain();
    word_q.push_back(mk(1'b1, 1023, 255, 1023));
    word_q.push_back(mk(1'b1, 5, 0, 0));
    word_q.push_back(mk(1'b1, 5, 0, 0));
    word_q.push_back(mk(1'b0, 0, 255, 1023));
    word_q.push_back(mk(1'b1, 65, 0, 0));
    drain();

    // random phases, each mode and core setting; allocations read only the
    // shadow at acceptance, so releases pick from the current pool state
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_ALLOC_MODE, modes[p]);
      write_reg(CFG_CORE_COUNT, cores[p]);
      for (int n = 0; n < 100; n++) begin
        word_q.push_back(rand_word(cores_eff()));
        // keep release picks close to the live pool
        while (word_q.size() > 2) @(posedge clk);
      end
    end
    // fill the whole pool to exhaustion in random mode
    drain();
    write_reg(CFG_ALLOC_MODE, MODE_RAND);
    for (int n = 0; n < POOL_SIZE - n_used + 3; n++)
      word_q.push_back(mk(1'b0, 0, 0, $urandom_range(0, 1023)));
    drain();

    $display("covered %0d words, %0d results, modes 0-4 and unused, core counts 0..15",
             n_accepted, n_checked);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bucket_pool_allocator.sv
verif/tb.sv
